FILE: hw/rtl/tesp_pkg.sv
// Shared constants, register codes and types for the tile extremum seed picker.
package tesp_pkg;

  // Parameter defaults
  localparam int unsigned MAX_TILE_COLS_DEF = 64;
  localparam int unsigned COORD_BITS_DEF    = 12;
  localparam int unsigned HEIGHT_BITS_DEF   = 32;

  // Fixed port widths
  localparam int unsigned IN_HEIGHT_BITS = 32;
  localparam int unsigned OUT_COORD_BITS = 12;
  localparam int unsigned REG_BITS       = 13;
  localparam int unsigned APB_ADDR_BITS  = 4;
  localparam int unsigned APB_DATA_BITS  = 32;

  // Register reset values (before clamping)
  localparam logic [REG_BITS-1:0] GRID_WIDTH_RST  = 13'd4096;
  localparam logic [REG_BITS-1:0] GRID_HEIGHT_RST = 13'd4096;
  localparam logic [REG_BITS-1:0] TILE_SIZE_RST   = 13'd64;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_TILE_SIZE   = 2'd2,
    REG_PICK_MAX    = 2'd3
  } reg_idx_e;

  // Per-cell scan flags from the raster counters to the tile stage
  typedef struct packed {
    logic in_range;  // tile column below the tracked limit
    logic tile_end;  // this cell closes its tile
  } scan_ctl_t;

endpackage

FILE: hw/rtl/tesp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tesp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/tesp_cfg.sv
// APB register file: grid width, grid height, tile size and pick mode.
module tesp_cfg import tesp_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output logic [COORD_BITS:0]      grid_width_o,
  output logic [COORD_BITS:0]      grid_height_o,
  output logic [COORD_BITS:0]      tile_size_o,
  output logic                     pick_max_o
);

  localparam int unsigned CRW = COORD_BITS + 1;
  localparam int unsigned CW  = (REG_BITS > CRW) ? REG_BITS : CRW;

  // Zero acts as one, anything above the coordinate range saturates
  function automatic logic [CRW-1:0] clamp(input logic [REG_BITS-1:0] v);
    logic [CW-1:0] w;
    logic [CW-1:0] lim;
    w   = CW'(v);
    lim = CW'(1) << COORD_BITS;
    if (w == '0) begin
      return CRW'(1);
    end else if (w > lim) begin
      return CRW'(lim);
    end else begin
      return CRW'(w);
    end
  endfunction

  logic [CRW-1:0] grid_width_q, grid_height_q, tile_size_q;
  logic           pick_max_q;
  logic           wr_en;
  reg_idx_e       idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= clamp(GRID_WIDTH_RST);
      grid_height_q <= clamp(GRID_HEIGHT_RST);
      tile_size_q   <= clamp(TILE_SIZE_RST);
      pick_max_q    <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_GRID_WIDTH:  grid_width_q  <= clamp(pwdata[REG_BITS-1:0]);
        REG_GRID_HEIGHT: grid_height_q <= clamp(pwdata[REG_BITS-1:0]);
        REG_TILE_SIZE:   tile_size_q   <= clamp(pwdata[REG_BITS-1:0]);
        REG_PICK_MAX:    pick_max_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_GRID_WIDTH:  prdata = APB_DATA_BITS'(grid_width_q);
      REG_GRID_HEIGHT: prdata = APB_DATA_BITS'(grid_height_q);
      REG_TILE_SIZE:   prdata = APB_DATA_BITS'(tile_size_q);
      REG_PICK_MAX:    prdata = APB_DATA_BITS'(pick_max_q);
      default:         prdata = '0;
    endcase
  end

  assign grid_width_o  = grid_width_q;
  assign grid_height_o = grid_height_q;
  assign tile_size_o   = tile_size_q;
  assign pick_max_o    = pick_max_q;

endmodule

FILE: hw/rtl/tesp_scan.sv
// Raster position counters: cell, position in tile and tile column.
module tesp_scan import tesp_pkg::*; #(
  parameter int unsigned COORD_BITS    = COORD_BITS_DEF,
  parameter int unsigned MAX_TILE_COLS = MAX_TILE_COLS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  logic [COORD_BITS:0]   grid_width_i,
  input  logic [COORD_BITS:0]   grid_height_i,
  input  logic [COORD_BITS:0]   tile_size_i,
  output logic [COORD_BITS-1:0] x_o,
  output logic [COORD_BITS-1:0] y_o,
  output logic [((MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1)-1:0] addr_o,
  output scan_ctl_t             ctl_o
);

  localparam int unsigned CRW = COORD_BITS + 1;
  localparam int unsigned AW  = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;
  localparam int unsigned TW  = $clog2(MAX_TILE_COLS + 1);

  logic [COORD_BITS-1:0] cell_col_q, cell_col_d, cell_row_q, cell_row_d;
  logic [COORD_BITS-1:0] col_in_tile_q, col_in_tile_d, row_in_tile_q, row_in_tile_d;
  logic [TW-1:0]         tile_col_q, tile_col_d;
  logic                  col_last, row_last, last_col_tile, last_row_tile, in_range;

  // Edge tests for the current cell
  assign col_last      = ({1'b0, cell_col_q} + CRW'(1)) >= grid_width_i;
  assign row_last      = ({1'b0, cell_row_q} + CRW'(1)) >= grid_height_i;
  assign last_col_tile = (({1'b0, col_in_tile_q} + CRW'(1)) >= tile_size_i) | col_last;
  assign last_row_tile = (({1'b0, row_in_tile_q} + CRW'(1)) >= tile_size_i) | row_last;
  assign in_range      = tile_col_q < TW'(MAX_TILE_COLS);

  // Advance the raster position, wrap at the end of the grid
  always_comb begin
    cell_col_d    = cell_col_q;
    cell_row_d    = cell_row_q;
    col_in_tile_d = col_in_tile_q;
    row_in_tile_d = row_in_tile_q;
    tile_col_d    = tile_col_q;
    if (col_last) begin
      cell_col_d    = '0;
      col_in_tile_d = '0;
      tile_col_d    = '0;
      if (row_last) begin
        cell_row_d    = '0;
        row_in_tile_d = '0;
      end else begin
        cell_row_d    = cell_row_q + 1'b1;
        row_in_tile_d = last_row_tile ? '0 : row_in_tile_q + 1'b1;
      end
    end else begin
      cell_col_d = cell_col_q + 1'b1;
      if (last_col_tile) begin
        col_in_tile_d = '0;
        if (in_range) begin
          tile_col_d = tile_col_q + 1'b1;
        end
      end else begin
        col_in_tile_d = col_in_tile_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_col_q    <= '0;
      cell_row_q    <= '0;
      col_in_tile_q <= '0;
      row_in_tile_q <= '0;
      tile_col_q    <= '0;
    end else if (advance_i) begin
      cell_col_q    <= cell_col_d;
      cell_row_q    <= cell_row_d;
      col_in_tile_q <= col_in_tile_d;
      row_in_tile_q <= row_in_tile_d;
      tile_col_q    <= tile_col_d;
    end
  end

  assign x_o            = cell_col_q;
  assign y_o            = cell_row_q;
  assign addr_o         = tile_col_q[AW-1:0];
  assign ctl_o.in_range = in_range;
  assign ctl_o.tile_end = last_col_tile & last_row_tile;

endmodule

FILE: hw/rtl/tesp_acc.sv
// Tile accumulator stage: compare against the stored best, update, emit seeds.
module tesp_acc import tesp_pkg::*; #(
  parameter int unsigned COORD_BITS    = COORD_BITS_DEF,
  parameter int unsigned HEIGHT_BITS   = HEIGHT_BITS_DEF,
  parameter int unsigned MAX_TILE_COLS = MAX_TILE_COLS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [COORD_BITS-1:0]  x_i,
  input  logic [COORD_BITS-1:0]  y_i,
  input  logic [((MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1)-1:0] addr_i,
  input  scan_ctl_t              ctl_i,
  input  logic [HEIGHT_BITS-1:0] height_i,
  input  logic                   occupied_i,
  input  logic                   pick_max_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [COORD_BITS-1:0]  seed_x_o,
  output logic [COORD_BITS-1:0]  seed_y_o
);

  localparam int unsigned AW = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;
  localparam int unsigned EW = HEIGHT_BITS + 2 * COORD_BITS;

  // Stage registers
  logic                   s1_v_q;
  logic [HEIGHT_BITS-1:0] s1_h_q;
  logic                   s1_occ_q;
  logic [COORD_BITS-1:0]  s1_x_q, s1_y_q;
  logic [AW-1:0]          s1_addr_q;
  scan_ctl_t              s1_ctl_q;
  logic                   fwd_hit_q;
  logic [EW-1:0]          fwd_q;
  logic [MAX_TILE_COLS-1:0] found_q;

  // Output register
  logic                  out_v_q;
  logic [COORD_BITS-1:0] out_x_q, out_y_q;

  logic [EW-1:0]          rd_data, entry, wr_data;
  logic [HEIGHT_BITS-1:0] best_h;
  logic [COORD_BITS-1:0]  best_x, best_y;
  logic                   found_cur, better, emit, out_free, s1_fire, wr_en;

  // Per-tile-column best entry {height, x, y}
  tesp_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TILE_COLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_data),
    .re_i    (accept_i),
    .raddr_i (addr_i),
    .rdata_o (rd_data)
  );

  // Take the write that raced the read, else the RAM data
  assign entry                   = fwd_hit_q ? fwd_q : rd_data;
  assign {best_h, best_x, best_y} = entry;
  assign found_cur               = found_q[s1_addr_q];

  // Compare; the earlier cell wins a tie
  always_comb begin
    better = 1'b0;
    if (s1_ctl_q.in_range && s1_occ_q) begin
      if (!found_cur) begin
        better = 1'b1;
      end else if (pick_max_i) begin
        better = $signed(s1_h_q) > $signed(best_h);
      end else begin
        better = $signed(s1_h_q) < $signed(best_h);
      end
    end
  end

  assign emit       = s1_ctl_q.in_range & s1_ctl_q.tile_end & (better | found_cur);
  assign out_free   = ~out_v_q | ~out_stall_i;
  assign s1_fire    = s1_v_q & (~emit | out_free);
  assign wr_en      = s1_fire & better;
  assign wr_data    = {s1_h_q, s1_x_q, s1_y_q};
  assign in_stall_o = s1_v_q & ~s1_fire;

  // Stage control and tile-found bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      fwd_hit_q <= 1'b0;
      found_q   <= '0;
    end else begin
      if (accept_i) begin
        s1_v_q    <= 1'b1;
        fwd_hit_q <= wr_en && (s1_addr_q == addr_i);
      end else if (s1_fire) begin
        s1_v_q <= 1'b0;
      end
      if (s1_fire && s1_ctl_q.in_range) begin
        if (s1_ctl_q.tile_end) begin
          found_q[s1_addr_q] <= 1'b0;
        end else if (better) begin
          found_q[s1_addr_q] <= 1'b1;
        end
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_h_q    <= height_i;
      s1_occ_q  <= occupied_i;
      s1_x_q    <= x_i;
      s1_y_q    <= y_i;
      s1_addr_q <= addr_i;
      s1_ctl_q  <= ctl_i;
      fwd_q     <= wr_data;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_fire && emit) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (s1_fire && emit) begin
      out_x_q <= better ? s1_x_q : best_x;
      out_y_q <= better ? s1_y_q : best_y;
    end
  end

  assign out_valid_o = out_v_q;
  assign seed_x_o    = out_x_q;
  assign seed_y_o    = out_y_q;

endmodule

FILE: hw/rtl/tile_extremum_seed_picker.sv
// Top level of the tile extremum seed picker.
//
//  channel  | signals                                   | accepted when
//  ---------+-------------------------------------------+----------------------------
//  cell in  | in_valid_i, in_stall_o, height_i, occ..   | in_valid_i & !in_stall_o
//  seed out | out_valid_o, out_stall_i, seed_x_o, _y_o  | out_valid_o & !out_stall_i
//  config   | psel, penable, pwrite, paddr, pwdata, ..  | psel & penable & pwrite
//
// One cell is taken every cycle while the input is not stalled. A cell is registered with its
// tile-column RAM read, then compared and written back, and its seed is registered for output.
// Back-to-back cells of one tile column are served by a write-to-read bypass.
// Reset clears the scan counters and the tile-found bits; no clearing pass is needed.
// The input stalls only while a seed is ready to go and the output register is held.
module tile_extremum_seed_picker import tesp_pkg::*; #(
  parameter int unsigned MAX_TILE_COLS = MAX_TILE_COLS_DEF,
  parameter int unsigned COORD_BITS    = COORD_BITS_DEF,
  parameter int unsigned HEIGHT_BITS   = HEIGHT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [IN_HEIGHT_BITS-1:0] height_i,
  input  logic                             occupied_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [OUT_COORD_BITS-1:0]        seed_x_o,
  output logic [OUT_COORD_BITS-1:0]        seed_y_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [APB_ADDR_BITS-1:0]         paddr,
  input  logic [APB_DATA_BITS-1:0]         pwdata,
  output logic [APB_DATA_BITS-1:0]         prdata,
  output logic                             pready
);

  localparam int unsigned AW = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;

  logic [COORD_BITS:0]     grid_width, grid_height, tile_size;
  logic                    pick_max, accept;
  logic [COORD_BITS-1:0]   scan_x, scan_y, acc_x, acc_y;
  logic [AW-1:0]           scan_addr;
  scan_ctl_t               scan_ctl;
  logic [IN_HEIGHT_BITS-1:0] h_raw;
  logic [HEIGHT_BITS-1:0]  h_ext;

  assign accept = in_valid_i & ~in_stall_o;

  // Keep the low height bits as two's complement
  assign h_raw = height_i;
  assign h_ext = HEIGHT_BITS'(h_raw);

  tesp_cfg #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .grid_width_o  (grid_width),
    .grid_height_o (grid_height),
    .tile_size_o   (tile_size),
    .pick_max_o    (pick_max)
  );

  tesp_scan #(
    .COORD_BITS    (COORD_BITS),
    .MAX_TILE_COLS (MAX_TILE_COLS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (accept),
    .grid_width_i  (grid_width),
    .grid_height_i (grid_height),
    .tile_size_i   (tile_size),
    .x_o           (scan_x),
    .y_o           (scan_y),
    .addr_o        (scan_addr),
    .ctl_o         (scan_ctl)
  );

  tesp_acc #(
    .COORD_BITS    (COORD_BITS),
    .HEIGHT_BITS   (HEIGHT_BITS),
    .MAX_TILE_COLS (MAX_TILE_COLS)
  ) u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .x_i         (scan_x),
    .y_i         (scan_y),
    .addr_i      (scan_addr),
    .ctl_i       (scan_ctl),
    .height_i    (h_ext),
    .occupied_i  (occupied_i),
    .pick_max_i  (pick_max),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .seed_x_o    (acc_x),
    .seed_y_o    (acc_y)
  );

  assign seed_x_o = OUT_COORD_BITS'(acc_x);
  assign seed_y_o = OUT_COORD_BITS'(acc_y);

endmodule

FILE: hw/rtl/tesp_checker.sv
// Port-level checker for the seed picker, bound to the top level.
module tesp_checker import tesp_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [OUT_COORD_BITS-1:0] seed_x_o,
  input logic [OUT_COORD_BITS-1:0] seed_y_o
);

  // Hold a stalled seed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(seed_x_o) && $stable(seed_y_o))
    else $error("stalled seed changed");

  // Stall the input only behind a held seed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held seed");

  // A new seed comes from an item that was accepted or from one held in the stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2) || $past(in_stall_o, 2))
    else $error("seed without a source item");

endmodule

bind tile_extremum_seed_picker tesp_checker u_tesp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .seed_x_o    (seed_x_o),
  .seed_y_o    (seed_y_o)
);

FILE: test/tesp_seed_checker.sv
// Seed checker: tracks the raster scan and tile extremes, compares predicted seeds to the block.
module tesp_seed_checker import tesp_pkg::*; (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cell_valid_i,
  input  logic                             cell_stall_i,
  input  logic signed [IN_HEIGHT_BITS-1:0] height_i,
  input  logic                             occupied_i,
  input  logic                             seed_valid_i,
  input  logic                             seed_stall_i,
  input  logic [OUT_COORD_BITS-1:0]        seed_x_i,
  input  logic [OUT_COORD_BITS-1:0]        seed_y_i,
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic                             pready_i,
  input  logic [APB_ADDR_BITS-1:0]         paddr_i,
  input  logic [APB_DATA_BITS-1:0]         pwdata_i,
  output int                               fail_cnt_o,
  output int                               pending_o
);

  localparam int unsigned TILES      = MAX_TILE_COLS_DEF;
  localparam int unsigned DIM_MAX    = 1 << COORD_BITS_DEF;
  localparam int unsigned REPORT_MAX = 10;

  typedef logic [COORD_BITS_DEF-1:0] coord_t;
  typedef logic [REG_BITS-1:0]       dim_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
  } seed_t;

  // Register copies, already clamped
  dim_t grid_w;
  dim_t grid_h;
  dim_t tile_w;
  logic pick_max;

  // Raster position
  coord_t                 col;
  coord_t                 row;
  coord_t                 col_in_tile;
  coord_t                 row_in_tile;
  logic [$clog2(TILES):0] tile_col;

  // Per tile column extremes
  logic signed [IN_HEIGHT_BITS-1:0] best_h [TILES];
  coord_t                           best_x [TILES];
  coord_t                           best_y [TILES];
  logic                             tile_found [TILES];

  seed_t seed_q [$];

  function automatic dim_t clamp_dim(dim_t v);
    if (v == '0) return dim_t'(1);
    if (v > DIM_MAX) return dim_t'(DIM_MAX);
    return v;
  endfunction

  // Fold one cell into its tile, queue a seed at the tile end, advance the scan
  task automatic track_cell(logic signed [IN_HEIGHT_BITS-1:0] h, logic occ);
    dim_t col_n;
    dim_t row_n;
    dim_t cit_n;
    dim_t rit_n;
    logic last_col;
    logic last_row;
    logic better;
    int   t;
    col_n    = col + 1'b1;
    row_n    = row + 1'b1;
    cit_n    = col_in_tile + 1'b1;
    rit_n    = row_in_tile + 1'b1;
    last_col = (cit_n >= tile_w) || (col_n >= grid_w);
    last_row = (rit_n >= tile_w) || (row_n >= grid_h);
    if (tile_col < TILES) begin
      t = tile_col;
      if (occ) begin
        if (!tile_found[t]) better = 1'b1;
        else if (pick_max) better = h > best_h[t];
        else better = h < best_h[t];
        if (better) begin
          tile_found[t] = 1'b1;
          best_h[t]     = h;
          best_x[t]     = col;
          best_y[t]     = row;
        end
      end
      if (last_col && last_row) begin
        if (tile_found[t]) seed_q.insert(seed_q.size(), {best_x[t], best_y[t]});
        tile_found[t] = 1'b0;
      end
    end
    if (col_n >= grid_w) begin
      col         = '0;
      col_in_tile = '0;
      tile_col    = '0;
      if (row_n >= grid_h) begin
        row         = '0;
        row_in_tile = '0;
      end else begin
        row         = row_n[COORD_BITS_DEF-1:0];
        row_in_tile = last_row ? '0 : rit_n[COORD_BITS_DEF-1:0];
      end
    end else begin
      col = col_n[COORD_BITS_DEF-1:0];
      if (last_col) begin
        col_in_tile = '0;
        if (tile_col < TILES) tile_col = tile_col + 1'b1;
      end else begin
        col_in_tile = cit_n[COORD_BITS_DEF-1:0];
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    seed_t want;
    if (!rst_ni) begin
      grid_w      = GRID_WIDTH_RST;
      grid_h      = GRID_HEIGHT_RST;
      tile_w      = TILE_SIZE_RST;
      pick_max    = 1'b0;
      col         = '0;
      row         = '0;
      col_in_tile = '0;
      row_in_tile = '0;
      tile_col    = '0;
      for (int i = 0; i < TILES; i++) tile_found[i] = 1'b0;
      seed_q.delete();
      fail_cnt_o  = 0;
    end else begin
      // Apply register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[3:2]))
          REG_GRID_WIDTH:  grid_w = clamp_dim(pwdata_i[REG_BITS-1:0]);
          REG_GRID_HEIGHT: grid_h = clamp_dim(pwdata_i[REG_BITS-1:0]);
          REG_TILE_SIZE:   tile_w = clamp_dim(pwdata_i[REG_BITS-1:0]);
          REG_PICK_MAX:    pick_max = pwdata_i[0];
          default: ;
        endcase
      end
      // Predict from each accepted cell
      if (cell_valid_i && !cell_stall_i) track_cell(height_i, occupied_i);
      // Compare each accepted seed with the oldest prediction
      if (seed_valid_i && !seed_stall_i) begin
        if (seed_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= REPORT_MAX)
            $display("unexpected seed: x=%0d y=%0d", seed_x_i, seed_y_i);
        end else begin
          want = seed_q.pop_front();
          if (seed_x_i !== want.x || seed_y_i !== want.y) begin
            fail_cnt_o++;
            if (fail_cnt_o <= REPORT_MAX)
              $display("seed mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                       want.x, want.y, seed_x_i, seed_y_i);
          end
        end
      end
    end
    pending_o = seed_q.size();
  end

endmodule

FILE: test/tb.sv
// Testbench top for the tile extremum seed picker: clock, reset, stimulus and verdict.
module tb;
  import tesp_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned NUM_PHASES    = 12;
  localparam logic signed [IN_HEIGHT_BITS-1:0] H_MIN = {1'b1, {(IN_HEIGHT_BITS-1){1'b0}}};
  localparam logic signed [IN_HEIGHT_BITS-1:0] H_MAX = {1'b0, {(IN_HEIGHT_BITS-1){1'b1}}};

  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             in_valid_i  = 1'b0;
  logic                             in_stall_o;
  logic signed [IN_HEIGHT_BITS-1:0] height_i    = '0;
  logic                             occupied_i  = 1'b0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic [OUT_COORD_BITS-1:0]        seed_x_o;
  logic [OUT_COORD_BITS-1:0]        seed_y_o;
  logic                             psel        = 1'b0;
  logic                             penable     = 1'b0;
  logic                             pwrite      = 1'b0;
  logic [APB_ADDR_BITS-1:0]         paddr       = '0;
  logic [APB_DATA_BITS-1:0]         pwdata      = '0;
  logic [APB_DATA_BITS-1:0]         prdata;
  logic                             pready;

  int   fail_cnt;
  int   pending;
  int   quiet_cycles = 0;
  int   idle_pct     = 0;
  int   stall_pct    = 0;
  logic hold_req     = 1'b0;

  tile_extremum_seed_picker u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .height_i    (height_i),
    .occupied_i  (occupied_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .seed_x_o    (seed_x_o),
    .seed_y_o    (seed_y_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  tesp_seed_checker u_seed_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_valid_i (in_valid_i),
    .cell_stall_i (in_stall_o),
    .height_i     (height_i),
    .occupied_i   (occupied_i),
    .seed_valid_i (out_valid_o),
    .seed_stall_i (out_stall_i),
    .seed_x_i     (seed_x_o),
    .seed_y_i     (seed_y_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Drop the run after too long without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stall the seed output at random; hold it off for a long stretch on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        repeat (HOLD_CYCLES) begin
          out_stall_i <= 1'b1;
          @(negedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic signed [IN_HEIGHT_BITS-1:0] rand_height();
    case ($urandom_range(5))
      0:       return H_MIN;
      1:       return H_MAX;
      2, 3:    return $urandom_range(8) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Write one register: setup, access, then idle with the bus released
  task automatic write_reg(reg_idx_e idx, int unsigned v);
    logic [APB_DATA_BITS-1:0] data;
    data                = $urandom;
    data[REG_BITS-1:0]  = v[REG_BITS-1:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Offer one cell after a random idle gap and hold it until accepted
  task automatic offer_cell(logic signed [IN_HEIGHT_BITS-1:0] h, logic occ);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    height_i   <= h;
    occupied_i <= occ;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Stop offering, wait for every predicted seed, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int n_cells;
    int occ_pct;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // 3x2 grid, 2x2 tiles: one full tile and one partial column tile
    write_reg(REG_GRID_WIDTH, 3);
    write_reg(REG_GRID_HEIGHT, 2);
    write_reg(REG_TILE_SIZE, 2);
    write_reg(REG_PICK_MAX, 0);
    // Lowest height, equal minimum later in the tile loses
    offer_cell(5, 1'b1);
    offer_cell(H_MIN, 1'b1);
    offer_cell(7, 1'b1);
    offer_cell(H_MIN, 1'b1);
    offer_cell(0, 1'b0);
    offer_cell(H_MAX, 1'b1);
    drain();

    // Highest height after the grid wrapped; right tile left empty
    write_reg(REG_PICK_MAX, 1);
    offer_cell(H_MAX, 1'b1);
    offer_cell(H_MAX, 1'b1);
    offer_cell(-1, 1'b0);
    offer_cell(-1, 1'b1);
    offer_cell(H_MIN, 1'b1);
    offer_cell(5, 1'b0);

    // Stop partway, then shrink the row so the next cell ends it
    repeat (4) offer_cell(rand_height(), 1'b1);
    drain();
    write_reg(REG_GRID_WIDTH, 1);
    write_reg(REG_TILE_SIZE, 8191);
    repeat (4) offer_cell(rand_height(), 1'($urandom_range(1)));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph % 4)
        0: begin
          idle_pct  = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct  = 54;
          stall_pct <= 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct <= 54;
        end
        default: begin
          idle_pct  = 18;
          stall_pct <= 18;
        end
      endcase
      n_cells = 50;
      occ_pct = $urandom_range(100, 20);
      case (ph)
        // Widest rows with one-cell tiles: columns past the tracked limit give nothing
        0: begin
          write_reg(REG_GRID_WIDTH, 4096);
          write_reg(REG_GRID_HEIGHT, 0);
          write_reg(REG_TILE_SIZE, 0);
          n_cells = 100;
          occ_pct = 100;
        end
        // Tallest grid, narrow rows
        1: begin
          write_reg(REG_GRID_WIDTH, 5);
          write_reg(REG_GRID_HEIGHT, 8191);
          write_reg(REG_TILE_SIZE, 3);
        end
        // A seed per cell while the output is held off
        2: begin
          write_reg(REG_GRID_WIDTH, 8);
          write_reg(REG_GRID_HEIGHT, 4);
          write_reg(REG_TILE_SIZE, 1);
          occ_pct = 100;
        end
        default: begin
          if ($urandom_range(9) == 0) write_reg(REG_GRID_WIDTH, $urandom_range(8191, 4097));
          else write_reg(REG_GRID_WIDTH, $urandom_range(12, 0));
          if ($urandom_range(7) == 0) write_reg(REG_GRID_HEIGHT, 4096);
          else write_reg(REG_GRID_HEIGHT, $urandom_range(6, 1));
          case ($urandom_range(6))
            0:       write_reg(REG_TILE_SIZE, 4096);
            1:       write_reg(REG_TILE_SIZE, 0);
            default: write_reg(REG_TILE_SIZE, $urandom_range(5, 1));
          endcase
        end
      endcase
      write_reg(REG_PICK_MAX, $urandom_range(1));
      if (ph == 2) begin
        hold_req <= 1'b1;
        @(negedge clk_i);
        hold_req <= 1'b0;
      end
      repeat (n_cells) offer_cell(rand_height(), $urandom_range(99) < occ_pct);
    end

    drain();
    if (fail_cnt == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
